>>> src/hapb_pkg.sv
// shared types and constants for the hit peak and baseline core
package hapb_pkg;

    localparam int CHANNELS_DEF = 32;
    localparam int LANES        = 4;
    localparam int ADC_W        = 16;
    localparam int GRP_W        = 3;
    localparam int CH_W         = 5;
    localparam int CNT_OUT_W    = 6;

    localparam logic [ADC_W-1:0] THR_RESET = 16'd4095;
    localparam logic [GRP_W-1:0] GRP_FIRST = 3'd0;
    localparam logic [GRP_W-1:0] GRP_LAST  = 3'd7;
    localparam logic             REG_THR   = 1'b0;

    localparam int FLG_T0_RST = 0;
    localparam int FLG_T1_RST = 1;
    localparam int FLG_T0_OVF = 2;

    typedef enum logic [1:0] {
        CLS_DATA  = 2'd0,
        CLS_RESET = 2'd1,
        CLS_SKIP  = 2'd2
    } hapb_class_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] peak_ch;
        logic [CH_W-1:0] pair_ch;
    } hapb_excl_t;

    typedef struct packed {
        logic [ADC_W-1:0] data;
        logic [ADC_W-1:0] value;
        logic             incl;
    } hapb_term_t;

endpackage

>>> src/hapb_lane.sv
// one lane: channel store for every fourth channel and baseline term qualification
module hapb_lane import hapb_pkg::*;
#(
    parameter int  CHANNELS = CHANNELS_DEF,
    parameter int  LANE     = 0,
    localparam int ROWS     = (CHANNELS + LANES - 1) / LANES,
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ROW_W-1:0]          wr_row,
    input  logic [ADC_W-1:0]          wr_data,
    input  logic [ROW_W-1:0]          rd_row,
    input  logic [ADC_W-1:0]          thr,
    input  hapb_excl_t                excl,
    output hapb_term_t                term
);

    logic [ADC_W-1:0] mem [ROWS];
    logic [ADC_W-1:0] rd_data_reg;
    logic [ROW_W-1:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        rd_data_reg <= mem[rd_row];
        rd_row_reg  <= rd_row;
    end

    always_comb
    begin
        int   ch;
        logic in_range;
        logic excluded;
        logic incl;
        ch       = int'(rd_row_reg) * LANES + LANE;
        in_range = ch < CHANNELS;
        excluded = excl.en && (ch == int'(excl.peak_ch) || ch == int'(excl.pair_ch));
        incl     = in_range && !excluded && (rd_data_reg <= thr);
        term.data  = rd_data_reg;
        term.value = incl ? rd_data_reg : '0;
        term.incl  = incl;
    end

endmodule

>>> src/hapb_div.sv
// restoring divider, one quotient bit per cycle
module hapb_div import hapb_pkg::*;
#(
    parameter int DVD_W = ADC_W + 6,
    parameter int DVS_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    trial;
    logic              fits;
    logic [DVS_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/hit_adc_peak_and_baseline_core.sv
// top level: input lanes, peak merge, baseline sweep and divide, result register
// flow: each group other than the last is taken while the core stays idle; after the last group
//   the core sweeps the ROWS = CHANNELS/4 store rows through the four lane memories, runs the
//   SUM_W = 16 + clog2(CHANNELS+1) divider steps and loads the result register
// a skipped hit goes straight to the result register; the next hit's groups wait until it is loaded
// rst_n clears control state, the running peak, the hit flags and sets the threshold to 4095
module hit_adc_peak_and_baseline_core import hapb_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // adc_0, adc_1, adc_2, adc_3, group_index, zero pad
    input  logic [2:0]  s_tuser,   // ts0_reset, ts1_reset, ts0_overflow
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // peak_value, peak_channel, pair_value, pair_channel,
                                   // baseline, baseline_count
    output logic [1:0]  m_tuser,   // hit_class
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROWS  = (CHANNELS + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int SUM_W = ADC_W + CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DIVIDE,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic             vld;
        logic [ADC_W-1:0] value;
        logic [CH_W-1:0]  ch;
    } cand_t;

    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        r = a;
        if (b.vld && (!a.vld || b.value > a.value))
        begin
            r = b;
        end
        return r;
    endfunction

    st_t               state_reg,   state_next;
    logic [ADC_W-1:0]  thr_reg;
    logic [2:0]        flags_reg,   flags_next;
    logic [ADC_W-1:0]  peak_reg,    peak_next;
    logic [CH_W-1:0]   peak_ch_reg, peak_ch_next;
    logic [ROW_W-1:0]  issue_row_reg, issue_row_next;
    logic              issue_done_reg, issue_done_next;
    logic              ret_vld_reg, ret_vld_next;
    logic [ROW_W-1:0]  ret_row_reg, ret_row_next;
    logic [SUM_W-1:0]  sum_reg,     sum_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [ADC_W-1:0]  pair_val_reg, pair_val_next;
    hapb_class_t       cls_reg,     cls_next;
    logic [ADC_W-1:0]  base_reg,    base_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    logic              acc;
    logic              cfg_wr;
    logic [GRP_W-1:0]  group;
    logic              lane_wr;
    logic [CH_W-1:0]   pair_ch;
    hapb_excl_t        excl;
    hapb_term_t        terms [LANES];
    logic              div_start;
    logic [CNT_W-1:0]  div_dvs;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign group    = s_tdata[66:64];
    assign lane_wr  = acc && (int'(group) < ROWS);
    assign pair_ch  = peak_ch_reg ^ CH_W'(1);

    assign excl.en      = (cls_reg == CLS_DATA);
    assign excl.peak_ch = peak_ch_reg;
    assign excl.pair_ch = pair_ch;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_THR) ? {16'd0, thr_reg} : 32'd0;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        hapb_lane #(
            .CHANNELS (CHANNELS),
            .LANE     (k)
        ) u_lane (
            .clk     (clk),
            .wr_en   (lane_wr),
            .wr_row  (ROW_W'(group)),
            .wr_data (s_tdata[k*ADC_W +: ADC_W]),
            .rd_row  (issue_row_reg),
            .thr     (thr_reg),
            .excl    (excl),
            .term    (terms[k])
        );
    end

    hapb_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        cand_t            c [LANES];
        cand_t            w01;
        cand_t            w23;
        cand_t            w;
        logic [ADC_W-1:0] base_peak;
        logic [SUM_W-1:0] tsum;
        logic [CNT_W-1:0] tcnt;
        logic             is_rst;
        logic             is_d;
        logic [CNT_OUT_W-1:0] bc;

        state_next      = state_reg;
        flags_next      = flags_reg;
        peak_next       = peak_reg;
        peak_ch_next    = peak_ch_reg;
        issue_row_next  = issue_row_reg;
        issue_done_next = issue_done_reg;
        ret_vld_next    = 1'b0;
        ret_row_next    = ret_row_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        pair_val_next   = pair_val_reg;
        cls_next        = cls_reg;
        base_next       = base_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        div_start       = 1'b0;

        for (int k = 0; k < LANES; k++)
        begin
            c[k].vld   = (int'(group) * LANES + k) < CHANNELS;
            c[k].value = s_tdata[k*ADC_W +: ADC_W];
            c[k].ch    = {group, 2'(k)};
        end
        w01 = pick(c[0], c[1]);
        w23 = pick(c[2], c[3]);
        w   = pick(w01, w23);
        base_peak = (group == GRP_FIRST) ? '0 : peak_reg;

        tsum = sum_reg;
        tcnt = cnt_reg;
        for (int k = 0; k < LANES; k++)
        begin
            tsum = tsum + SUM_W'(terms[k].value);
            tcnt = tcnt + CNT_W'(terms[k].incl);
        end

        is_rst = flags_reg[FLG_T0_RST] || flags_reg[FLG_T1_RST];
        is_d   = (cls_reg == CLS_DATA);
        bc     = (int'(cnt_reg) > 63) ? CNT_OUT_W'(63) : CNT_OUT_W'(cnt_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (group == GRP_FIRST)
                    begin
                        flags_next   = s_tuser;
                        peak_next    = '0;
                        peak_ch_next = '0;
                    end
                    if (w.vld && w.value > base_peak)
                    begin
                        peak_next    = w.value;
                        peak_ch_next = w.ch;
                    end
                    if (group == GRP_LAST)
                    begin
                        if (!is_rst && flags_reg[FLG_T0_OVF])
                        begin
                            cls_next   = CLS_SKIP;
                            base_next  = '0;
                            cnt_next   = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cls_next        = is_rst ? CLS_RESET : CLS_DATA;
                            sum_next        = '0;
                            cnt_next        = '0;
                            pair_val_next   = '0;
                            issue_row_next  = '0;
                            issue_done_next = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!issue_done_reg)
                begin
                    ret_vld_next = 1'b1;
                    ret_row_next = issue_row_reg;
                    if (int'(issue_row_reg) == ROWS - 1)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_row_next = issue_row_reg + 1'b1;
                    end
                end
                if (ret_vld_reg)
                begin
                    sum_next = tsum;
                    cnt_next = tcnt;
                    if (int'(pair_ch) < CHANNELS && int'(ret_row_reg) == int'(pair_ch[4:2]))
                    begin
                        pair_val_next = terms[pair_ch[1:0]].data;
                    end
                    if (int'(ret_row_reg) == ROWS - 1)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    base_next  = ADC_W'(div_quo);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = cls_reg;
                    m_tdata_next  = {bc, base_reg,
                                     is_d ? pair_ch : '0,
                                     is_d ? pair_val_reg : '0,
                                     is_d ? peak_ch_reg : '0,
                                     is_d ? peak_reg : '0};
                    peak_next     = '0;
                    peak_ch_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_dvs = (cnt_next == '0) ? CNT_W'(1) : cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            flags_reg      <= '0;
            peak_reg       <= '0;
            peak_ch_reg    <= '0;
            issue_row_reg  <= '0;
            issue_done_reg <= 1'b0;
            ret_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cls_reg        <= CLS_DATA;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr && paddr[2] == REG_THR)
            begin
                thr_reg <= pwdata[ADC_W-1:0];
            end
            flags_reg      <= flags_next;
            peak_reg       <= peak_next;
            peak_ch_reg    <= peak_ch_next;
            issue_row_reg  <= issue_row_next;
            issue_done_reg <= issue_done_next;
            ret_vld_reg    <= ret_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
            cls_reg        <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_row_reg  <= ret_row_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        pair_val_reg <= pair_val_next;
        base_reg     <= base_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide phase");

    a_pair_of_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == CLS_DATA) |-> m_tdata[41:37] == (m_tdata[20:16] ^ 5'd1))
        else $error("pair channel is not the neighbor of the peak channel");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == CLS_SKIP) |-> m_tdata == 64'd0)
        else $error("skipped hit carries nonzero result fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(m_tdata[63:58]) <= CHANNELS)
        else $error("baseline count exceeds the channel count");
`endif

endmodule

>>> tb/sv/tb_hit_adc_peak_and_baseline_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the hit peak and baseline core with random idling on both streams
module tb_hit_adc_peak_and_baseline_core;
    import hapb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int PHASES         = 5;

    localparam logic [2:0] ADDR_THR   = 3'(REG_THR) << 2;
    localparam logic [2:0] FLAGS_NONE = 3'b000;
    localparam logic [2:0] FLAG_T0    = 3'(1 << FLG_T0_RST);
    localparam logic [2:0] FLAG_T1    = 3'(1 << FLG_T1_RST);
    localparam logic [2:0] FLAG_OVF   = 3'(1 << FLG_T0_OVF);

    typedef struct packed {
        hapb_class_t          hit_class;
        logic [CNT_OUT_W-1:0] baseline_count;
        logic [ADC_W-1:0]     baseline;
        logic [CH_W-1:0]      pair_channel;
        logic [ADC_W-1:0]     pair_value;
        logic [CH_W-1:0]      peak_channel;
        logic [ADC_W-1:0]     peak_value;
    } hit_summary_t;

    class hit_summary_model;
        logic [ADC_W-1:0] adc_mem [CHANNELS_DEF];
        logic [ADC_W-1:0] peak_val;
        logic [CH_W-1:0]  peak_chan;
        logic [2:0]       flags;
        logic [ADC_W-1:0] threshold;
        hit_summary_t     due_summaries [$];
        int               mismatches;
        int               checked;
        int               class_seen [3];

        function new();
            foreach (adc_mem[i])
                adc_mem[i] = '0;
            peak_val   = '0;
            peak_chan  = '0;
            flags      = FLAGS_NONE;
            threshold  = THR_RESET;
            mismatches = 0;
            checked    = 0;
            foreach (class_seen[i])
                class_seen[i] = 0;
        endfunction

        function void note_group(logic [LANES-1:0][ADC_W-1:0] adc, logic [GRP_W-1:0] grp,
                                 logic [2:0] user);
            hit_summary_t res;
            logic is_reset;
            logic is_data;
            logic [CH_W-1:0] ch;
            logic [CH_W-1:0] pair;
            int sum;
            int count;
            if (grp == GRP_FIRST)
            begin
                peak_val  = '0;
                peak_chan = '0;
                flags     = user;
            end
            for (int k = 0; k < LANES; k++)
            begin
                ch = CH_W'(int'(grp) * LANES + k);
                adc_mem[ch] = adc[k];
                if (adc[k] > peak_val)
                begin
                    peak_val  = adc[k];
                    peak_chan = ch;
                end
            end
            if (grp != GRP_LAST)
                return;
            res      = '0;
            is_reset = flags[FLG_T0_RST] | flags[FLG_T1_RST];
            is_data  = !is_reset && !flags[FLG_T0_OVF];
            if (!is_reset && !is_data)
                res.hit_class = CLS_SKIP;
            else
            begin
                pair  = peak_chan ^ 5'd1;
                sum   = 0;
                count = 0;
                for (int c = 0; c < CHANNELS_DEF; c++)
                begin
                    if (is_data && (c == peak_chan || c == pair))
                        continue;
                    if (adc_mem[c] > threshold)
                        continue;
                    sum += adc_mem[c];
                    count++;
                end
                res.hit_class = is_data ? CLS_DATA : CLS_RESET;
                if (is_data)
                begin
                    res.peak_value   = peak_val;
                    res.peak_channel = peak_chan;
                    res.pair_value   = adc_mem[pair];
                    res.pair_channel = pair;
                end
                res.baseline       = ADC_W'(sum / (count == 0 ? 1 : count));
                res.baseline_count = CNT_OUT_W'(count);
            end
            class_seen[res.hit_class]++;
            due_summaries.push_back(res);
            peak_val  = '0;
            peak_chan = '0;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_summary(hit_summary_t got);
            hit_summary_t want;
            checked++;
            if (due_summaries.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual class %0d baseline %0d",
                         $time, got.hit_class, got.baseline);
                return;
            end
            want = due_summaries.pop_front();
            compare_field("hit_class", want.hit_class, got.hit_class);
            compare_field("peak_value", want.peak_value, got.peak_value);
            compare_field("peak_channel", want.peak_channel, got.peak_channel);
            compare_field("pair_value", want.pair_value, got.pair_value);
            compare_field("pair_channel", want.pair_channel, got.pair_channel);
            compare_field("baseline", want.baseline, got.baseline);
            compare_field("baseline_count", want.baseline_count, got.baseline_count);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // adc_0, adc_1, adc_2, adc_3, group_index, zero pad
    logic [2:0]  s_tuser;   // ts0_reset, ts1_reset, ts0_overflow
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // peak_value, peak_channel, pair_value, pair_channel, baseline,
                            // baseline_count
    logic [1:0]  m_tuser;   // hit_class
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hit_summary_model hits = new();
    bit no_idle     = 1'b0;
    int items_sent  = 0;
    int quiet_cycles = 0;

    hit_adc_peak_and_baseline_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("hit_adc_peak_and_baseline_core test failed");
            $finish;
        end
    end

    task automatic send_group(input logic [GRP_W-1:0] grp, input logic [2:0] user,
                              input logic [LANES-1:0][ADC_W-1:0] adc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, grp, adc};
        s_tuser  = user;
        do @(posedge clk); while (!s_tready);
        hits.note_group(adc, grp, user);
        items_sent++;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_THR)
            hits.threshold = data[ADC_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            hits.mismatches++;
            $display("%0t: register read mismatch, expected %0d, actual %0d",
                     $time, want, prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // drop valid and let the core drain before touching the threshold
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (hits.due_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ADC_W-1:0] pick_adc(logic [ADC_W-1:0] tie_val);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return tie_val;
            3:       return ADC_W'(hits.threshold + $urandom_range(0, 2) - 1);
            4:       return ADC_W'($urandom_range(0, 255));
            default: return ADC_W'($urandom);
        endcase
    endfunction

    task automatic send_random_hit();
        logic [GRP_W-1:0]            seq [$];
        logic [ADC_W-1:0]            tie_val;
        logic [LANES-1:0][ADC_W-1:0] adc;
        logic [2:0]                  user;
        int                          shape;
        int                          len;
        tie_val = ADC_W'($urandom);
        user    = ($urandom_range(0, 1) == 0) ? 3'($urandom) : FLAGS_NONE;
        shape   = $urandom_range(0, 9);
        no_idle = ($urandom_range(0, 5) == 0);
        if (shape == 7)
        begin
            // first group missing, flags of the previous hit stay
            for (int g = 1; g <= GRP_LAST; g++)
                seq.push_back(GRP_W'(g));
        end
        else if (shape == 8)
        begin
            // scrambled and repeated groups
            len = $urandom_range(2, 9);
            repeat (len) seq.push_back(GRP_W'($urandom_range(0, GRP_LAST)));
            seq.push_back(GRP_LAST);
        end
        else if (shape == 9)
        begin
            // hit cut short, never closed
            len = $urandom_range(0, GRP_LAST - 1);
            for (int g = 0; g <= len; g++)
                seq.push_back(GRP_W'(g));
        end
        else
        begin
            for (int g = 0; g <= GRP_LAST; g++)
                seq.push_back(GRP_W'(g));
        end
        foreach (seq[i])
        begin
            for (int k = 0; k < LANES; k++)
                adc[k] = pick_adc(tie_val);
            send_group(seq[i], (seq[i] == GRP_FIRST) ? user : 3'($urandom), adc);
        end
    endtask

    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap == 0)
            begin
                @(negedge clk);
                m_tready = 1'b1;
            end
            else
            begin
                @(negedge clk);
                m_tready = 1'b0;
                do @(posedge clk); while (!m_tvalid);
                repeat (gap) @(negedge clk);
                m_tready = 1'b1;
            end
            do @(posedge clk); while (!m_tvalid);
            hits.check_summary({m_tuser, m_tdata});
        end
    end

    initial
    begin : stimulus
        logic [ADC_W-1:0]            thr_set [PHASES];
        logic [LANES-1:0][ADC_W-1:0] adc;
        int                          target;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apb_read_check(ADDR_THR, 32'(THR_RESET));

        // all-zero data hit, peak falls back to channel 0
        for (int g = 0; g <= GRP_LAST; g++)
            send_group(GRP_W'(g), FLAGS_NONE, '0);

        // data hit with tied full-scale peaks and values on both sides of the threshold
        for (int g = 0; g <= GRP_LAST; g++)
        begin
            adc = {(g == 2 || g == 5) ? 16'hFFFF : 16'h0000, THR_RESET + 16'd1, THR_RESET,
                   ADC_W'(100 * g)};
            send_group(GRP_W'(g), FLAGS_NONE, adc);
        end

        // reset hit from T1 with overflow also set
        for (int g = 0; g <= GRP_LAST; g++)
        begin
            adc = {ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom)};
            send_group(GRP_W'(g), FLAG_T1 | FLAG_OVF, adc);
        end

        // skipped hit carried by its first and last groups only
        adc = {ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom)};
        send_group(GRP_FIRST, FLAG_OVF, adc);
        send_group(GRP_LAST, FLAG_T0, adc);

        thr_set = '{16'h0000, 16'hFFFF, ADC_W'($urandom_range(1, 65534)),
                    ADC_W'($urandom_range(0, 1023)), THR_RESET};
        foreach (thr_set[p])
        begin
            wait_idle();
            apb_write(ADDR_THR, 32'(thr_set[p]));
            apb_read_check(ADDR_THR, 32'(thr_set[p]));
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                send_random_hit();
        end
        wait_idle();

        $display("%0d group transfers, %0d results checked over %0d threshold settings",
                 items_sent, hits.checked, PHASES + 1);
        $display("classes seen: %0d data, %0d reset, %0d skipped",
                 hits.class_seen[CLS_DATA], hits.class_seen[CLS_RESET],
                 hits.class_seen[CLS_SKIP]);
        if (hits.mismatches == 0 && hits.due_summaries.size() == 0)
            $display("hit_adc_peak_and_baseline_core test passed");
        else
            $display("hit_adc_peak_and_baseline_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
src/hapb_pkg.sv
src/hapb_lane.sv
src/hapb_div.sv
src/hit_adc_peak_and_baseline_core.sv
tb/sv/tb_hit_adc_peak_and_baseline_core.sv
